>>> rtl/ffp_pkg.sv
// ============================================================================
// ffp_pkg
// Shared types, constants and index helpers for the fundamental matrix core.
// ============================================================================
package ffp_pkg;

    // Width of the exact determinant accumulator.
    localparam int ACC_W = 132;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MINOR,
        S_PROD,
        S_EMIT
    } state_t;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic       load;         // store the accepted element
        logic [1:0] elem;         // element of the current 2x2 minor to read
        logic [3:0] minor_idx;    // minor being formed, 0..5 first camera, 6..11 second
        logic [1:0] ent_i;        // output row of the current entry
        logic [1:0] ent_j;        // output column of the current entry
        logic       opa_load;     // capture the read word as first factor
        logic       mul_en;       // multiply factor by read word
        logic       minor_load;   // capture first minor product
        logic       minor_store;  // subtract second product and store minor
        logic       acc_clear;    // clear the determinant accumulator
        logic       pp_en;        // form one partial product of a minor pair
        logic [1:0] pp_sel;       // which 32-bit halves go into the partial product
        logic       acc_en;       // accumulate the registered partial product
        logic [1:0] acc_sel;      // halves of the partial product being accumulated
        logic [2:0] pair;         // column pair of the Laplace expansion
        logic       emit;         // present the finished entry
        logic       emit_last;    // the entry is the ninth one
    } cmd_t;

    // Row that follows base by off places, modulo three.
    function automatic logic [1:0] rot_row(input logic [1:0] base, input logic [1:0] off);
        logic [2:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= 3'd3)
            s = s - 3'd3;
        return s[1:0];
    endfunction

    // Column of a Laplace pair: pairs are (0,1) (0,2) (0,3) (1,2) (1,3) (2,3).
    function automatic logic [1:0] pair_col(input logic [2:0] p, input logic second);
        logic [1:0] c;
        case (p)
            3'd0: c = second ? 2'd1 : 2'd0;
            3'd1: c = second ? 2'd2 : 2'd0;
            3'd2: c = second ? 2'd3 : 2'd0;
            3'd3: c = second ? 2'd2 : 2'd1;
            3'd4: c = second ? 2'd3 : 2'd1;
            3'd5: c = second ? 2'd3 : 2'd2;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // Sign of the Laplace term for a column pair.
    function automatic logic pair_neg(input logic [2:0] p);
        return (p == 3'd1) || (p == 3'd4);
    endfunction

    // Store address of an element of a 2x2 minor. Minors 6..11 use the
    // complementary column pair on the second camera, so that minor k of the
    // first camera and minor k+6 of the second form one expansion term.
    function automatic logic [4:0] elem_addr(input logic [1:0] ei, input logic [1:0] ej,
                                             input logic [3:0] k, input logic [1:0] e);
        logic       is_b;
        logic [2:0] p;
        logic [1:0] r;
        logic [1:0] c;
        is_b = (k >= 4'd6);
        p    = is_b ? (3'd5 - (k[2:0] - 3'd6)) : k[2:0];
        r    = rot_row(is_b ? ei : ej, e[1] ? 2'd2 : 2'd1);
        c    = pair_col(p, e[0]);
        return (is_b ? 5'd12 : 5'd0) + {1'b0, r, 2'b00} + {3'b000, c};
    endfunction

endpackage

>>> rtl/ffp_datapath.sv
// ============================================================================
// ffp_datapath
// Element store, shared multiplier, minor bank and exact determinant
// accumulator with scaling, saturation and result registers.
// ============================================================================
module ffp_datapath #(
    parameter int FRAC_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffp_pkg::cmd_t        cmd,
    input  logic                 camera,
    input  logic [1:0]           row,
    input  logic [1:0]           col,
    input  logic signed [31:0]   value,
    output logic [1:0]           out_row,
    output logic [1:0]           out_col,
    output logic signed [63:0]   entry_value,
    output logic                 end_of_matrix,
    output logic                 result_valid
);

    localparam int SHIFT = 3 * FRAC_BITS;
    localparam int AW    = ffp_pkg::ACC_W;

    logic [31:0]           store_mem [24];
    logic [31:0]           rd_reg;
    logic [31:0]           opa_reg;
    logic [63:0]           prod_reg;
    logic signed [63:0]    minor_acc_reg;
    logic signed [64:0]    minor_a_reg [6];
    logic signed [64:0]    minor_b_reg [6];
    logic signed [AW-1:0]  acc_reg;
    logic [1:0]            out_row_reg;
    logic [1:0]            out_col_reg;
    logic signed [63:0]    entry_reg;
    logic                  end_reg;
    logic                  valid_reg;

    logic [4:0]            wr_addr;
    logic [4:0]            rd_addr;
    logic signed [32:0]    mul_x;
    logic signed [32:0]    mul_y;
    logic signed [65:0]    mul_p;
    logic signed [64:0]    minor_a;
    logic signed [64:0]    minor_b;
    logic [63:0]           mag_a;
    logic [63:0]           mag_b;
    logic                  term_neg;
    logic [AW-1:0]         term;
    logic [1:0]            term_sh;
    logic signed [AW-1:0]  shifted;
    logic [AW-64:0]        upper;
    logic signed [63:0]    sat_value;
    logic signed [64:0]    minor_diff;

    // Store addressing.
    assign wr_addr = (camera ? 5'd12 : 5'd0) + {1'b0, row, 2'b00} + {3'b000, col};
    assign rd_addr = ffp_pkg::elem_addr(cmd.ent_i, cmd.ent_j, cmd.minor_idx, cmd.elem);

    // Element store with registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load && row != 2'd3)
            store_mem[wr_addr] <= value;
        rd_reg <= store_mem[rd_addr];
    end

    // Current minor pair and their magnitudes.
    assign minor_a  = minor_a_reg[cmd.pair];
    assign minor_b  = minor_b_reg[cmd.pair];
    assign mag_a    = minor_a[64] ? 64'(-minor_a) : minor_a[63:0];
    assign mag_b    = minor_b[64] ? 64'(-minor_b) : minor_b[63:0];
    assign term_neg = minor_a[64] ^ minor_b[64] ^ ffp_pkg::pair_neg(cmd.pair);

    // Shared multiplier: signed elements for minors, unsigned halves for terms.
    always_comb
    begin
        if (cmd.pp_en)
        begin
            mul_x = {1'b0, (cmd.pp_sel[0] ? mag_a[63:32] : mag_a[31:0])};
            mul_y = {1'b0, (cmd.pp_sel[1] ? mag_b[63:32] : mag_b[31:0])};
        end
        else
        begin
            mul_x = {opa_reg[31], opa_reg};
            mul_y = {rd_reg[31], rd_reg};
        end
    end
    assign mul_p = mul_x * mul_y;

    // Partial product aligned to its place in the accumulator.
    assign term_sh = {cmd.acc_sel[0] & cmd.acc_sel[1], cmd.acc_sel[0] ^ cmd.acc_sel[1]};
    assign term    = AW'(prod_reg) << {term_sh, 5'b00000};

    assign minor_diff = 65'(minor_acc_reg) - 65'(signed'(prod_reg));

    // Operand, product, minor and accumulator registers.
    always_ff @(posedge clk)
    begin
        if (cmd.opa_load)
            opa_reg <= rd_reg;
        if (cmd.mul_en || cmd.pp_en)
            prod_reg <= mul_p[63:0];
        if (cmd.minor_load)
            minor_acc_reg <= prod_reg;
        if (cmd.minor_store)
        begin
            if (cmd.minor_idx < 4'd6)
                minor_a_reg[cmd.minor_idx[2:0]] <= minor_diff;
            else
                minor_b_reg[3'(cmd.minor_idx - 4'd6)] <= minor_diff;
        end
        if (cmd.acc_clear)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= term_neg ? (acc_reg - term) : (acc_reg + term);
    end

    // Scale back and saturate to 64 bits.
    assign shifted   = acc_reg >>> SHIFT;
    assign upper     = shifted[AW-1:63];
    assign sat_value = ((&upper) || !(|upper)) ? shifted[63:0]
                     : (acc_reg[AW-1] ? 64'sh8000000000000000 : 64'sh7FFFFFFFFFFFFFFF);

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg <= cmd.ent_i;
            out_col_reg <= cmd.ent_j;
            entry_reg   <= sat_value;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            end_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            end_reg   <= cmd.emit && cmd.emit_last;
        end
    end

    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign entry_value   = entry_reg;
    assign end_of_matrix = end_reg;
    assign result_valid  = valid_reg;

endmodule

>>> rtl/ffp_ctrl.sv
// ============================================================================
// ffp_ctrl
// Sequencer for loading, minor formation, term accumulation and emission.
// ============================================================================
module ffp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           last,
    output logic           busy,
    output ffp_pkg::cmd_t  cmd
);

    ffp_pkg::state_t state_reg, state_next;
    logic [1:0] i_reg, i_next;
    logic [1:0] j_reg, j_next;
    logic [3:0] k_reg, k_next;
    logic [2:0] cyc_reg, cyc_next;
    logic       accept;

    assign accept = start && (state_reg == ffp_pkg::S_IDLE);
    assign busy   = (state_reg != ffp_pkg::S_IDLE);

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffp_pkg::S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            cyc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            cyc_reg   <= cyc_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cyc_next   = cyc_reg;
        case (state_reg)
            ffp_pkg::S_IDLE:
            begin
                if (accept && last)
                    state_next = ffp_pkg::S_MINOR;
            end
            ffp_pkg::S_MINOR:
            begin
                if (cyc_reg == 3'd5)
                begin
                    cyc_next = '0;
                    if (k_reg == 4'd11)
                    begin
                        k_next     = '0;
                        state_next = ffp_pkg::S_PROD;
                    end
                    else
                        k_next = k_reg + 4'd1;
                end
                else
                    cyc_next = cyc_reg + 3'd1;
            end
            ffp_pkg::S_PROD:
            begin
                if (cyc_reg == 3'd4)
                begin
                    cyc_next = '0;
                    if (k_reg == 4'd5)
                    begin
                        k_next     = '0;
                        state_next = ffp_pkg::S_EMIT;
                    end
                    else
                        k_next = k_reg + 4'd1;
                end
                else
                    cyc_next = cyc_reg + 3'd1;
            end
            ffp_pkg::S_EMIT:
            begin
                state_next = ffp_pkg::S_MINOR;
                if (j_reg == 2'd2)
                begin
                    j_next = '0;
                    if (i_reg == 2'd2)
                    begin
                        i_next     = '0;
                        state_next = ffp_pkg::S_IDLE;
                    end
                    else
                        i_next = i_reg + 2'd1;
                end
                else
                    j_next = j_reg + 2'd1;
            end
            default:
                state_next = ffp_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.minor_idx = k_reg;
        cmd.ent_i     = i_reg;
        cmd.ent_j     = j_reg;
        cmd.pair      = k_reg[2:0];
        cmd.pp_sel    = cyc_reg[1:0];
        cmd.acc_sel   = 2'(cyc_reg - 3'd1);
        case (state_reg)
            ffp_pkg::S_MINOR:
            begin
                // Read order: a, d, b, c of the minor ad - bc.
                case (cyc_reg)
                    3'd0:    cmd.elem = 2'd0;
                    3'd1:    cmd.elem = 2'd3;
                    3'd2:    cmd.elem = 2'd1;
                    default: cmd.elem = 2'd2;
                endcase
                cmd.opa_load    = (cyc_reg == 3'd1) || (cyc_reg == 3'd3);
                cmd.mul_en      = (cyc_reg == 3'd2) || (cyc_reg == 3'd4);
                cmd.minor_load  = (cyc_reg == 3'd3);
                cmd.minor_store = (cyc_reg == 3'd5);
                cmd.acc_clear   = (cyc_reg == 3'd0) && (k_reg == 4'd0);
            end
            ffp_pkg::S_PROD:
            begin
                cmd.pp_en  = (cyc_reg < 3'd4);
                cmd.acc_en = (cyc_reg != 3'd0);
            end
            ffp_pkg::S_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = (i_reg == 2'd2) && (j_reg == 2'd2);
            end
            default:
            begin
                cmd.elem = 2'd0;
            end
        endcase
    end

endmodule

>>> rtl/fundamental_from_projections_core.sv
// ============================================================================
// fundamental_from_projections_core
// Builds the 3x3 fundamental matrix from two 3x4 projection matrices.
// ============================================================================
// Elements are loaded one per cycle while busy is low. The item marked last
// starts the computation: each of the nine entries is formed from twelve 2x2
// minors (on the one shared multiplier and the element store) and six exact
// 128-bit expansion terms (each as four 32x32 partial products), then scaled
// and saturated. Results are shown for one cycle only and cannot be held off;
// busy stays high until the ninth entry has been issued.
module fundamental_from_projections_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                camera,
    input  logic [1:0]          row,
    input  logic [1:0]          col,
    input  logic signed [31:0]  value,
    input  logic                last,
    output logic                result_valid,
    output logic [1:0]          out_row,
    output logic [1:0]          out_col,
    output logic signed [63:0]  entry_value,
    output logic                end_of_matrix
);

    ffp_pkg::cmd_t cmd;

    // Sequencer.
    ffp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Arithmetic and storage.
    ffp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .camera        (camera),
        .row           (row),
        .col           (col),
        .value         (value),
        .out_row       (out_row),
        .out_col       (out_col),
        .entry_value   (entry_value),
        .end_of_matrix (end_of_matrix),
        .result_valid  (result_valid)
    );

endmodule

>>> rtl/ffp_checker.sv
// ============================================================================
// ffp_checker
// Port-level checks on the result sequence of the fundamental matrix core.
// ============================================================================
module ffp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        last,
    input logic        result_valid,
    input logic [1:0]  out_row,
    input logic [1:0]  out_col,
    input logic        end_of_matrix
);

    // Every result carries a legal matrix position.
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (out_row != 2'd3) && (out_col != 2'd3))
        else $error("result position out of range");

    // The closing transaction is the bottom-right entry.
    a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_matrix |-> (out_row == 2'd2) && (out_col == 2'd2))
        else $error("end of matrix on wrong entry");

    // A plain load does not start a computation.
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last |=> !busy)
        else $error("load without last made the core busy");

    // A new computation never opens with a result.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !result_valid)
        else $error("result at start of computation");

endmodule

bind fundamental_from_projections_core ffp_checker u_ffp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .last          (last),
    .result_valid  (result_valid),
    .out_row       (out_row),
    .out_col       (out_col),
    .end_of_matrix (end_of_matrix)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: fundamental_from_projections_core regression
// Loads both projection matrices through the command port and triggers
// fundamental matrix computations. A local predictor forms each entry as an
// exact 4x4 determinant, scales and saturates it, and the monitor checks every
// emitted entry field by field. The sender idles at several rates.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int FRAC_BITS  = 12;
    localparam int WDOG_LIMIT = 6000;
    localparam int NUM_RAND   = 80;

    // One load transaction.
    typedef struct {
        logic              camera;
        logic [1:0]        row;
        logic [1:0]        col;
        logic signed [31:0] value;
        logic              last;
    } load_t;

    // One fundamental matrix entry.
    typedef struct {
        logic [1:0]         r;
        logic [1:0]         c;
        logic signed [63:0] v;
        logic               eom;
    } entry_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               camera;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] value;
    logic               last;
    logic               result_valid;
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [63:0] entry_value;
    logic               end_of_matrix;

    load_t  load_queue[$];
    entry_t entry_queue[$];
    logic signed [31:0] proj_store[24];
    int     loads_taken;
    int     entries_seen;
    int     mismatches;
    int     idle_pct;
    int     quiet_cycles;
    bit     stim_done;

    fundamental_from_projections_core #(.FRAC_BITS(FRAC_BITS)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .camera(camera), .row(row), .col(col), .value(value), .last(last),
        .result_valid(result_valid), .out_row(out_row), .out_col(out_col),
        .entry_value(entry_value), .end_of_matrix(end_of_matrix)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Exact determinant of the 4x4 stack for entry (i,j), scaled and saturated.
    function automatic logic signed [63:0] fund_entry(input int i, input int j);
        logic signed [31:0]  m[4][4];
        logic signed [159:0] sum;
        logic signed [159:0] term;
        logic signed [159:0] sh;
        int perm[4];
        int inv;
        sum = '0;
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[r][c]     = proj_store[((j + 1 + r) % 3) * 4 + c];
                m[r + 2][c] = proj_store[12 + ((i + 1 + r) % 3) * 4 + c];
            end
        end
        for (int p0 = 0; p0 < 4; p0++)
            for (int p1 = 0; p1 < 4; p1++)
                for (int p2 = 0; p2 < 4; p2++)
                begin
                    if (p1 != p0 && p2 != p0 && p2 != p1)
                    begin
                        perm[0] = p0; perm[1] = p1; perm[2] = p2;
                        perm[3] = 6 - p0 - p1 - p2;
                        inv = 0;
                        for (int a = 0; a < 4; a++)
                            for (int b = a + 1; b < 4; b++)
                                if (perm[a] > perm[b])
                                    inv++;
                        term = 160'(m[0][perm[0]]);
                        term = term * 160'(m[1][perm[1]]);
                        term = term * 160'(m[2][perm[2]]);
                        term = term * 160'(m[3][perm[3]]);
                        if (inv % 2)
                            sum = sum - term;
                        else
                            sum = sum + term;
                    end
                end
        sh = sum >>> (3 * FRAC_BITS);
        if (sh[159:63] == {97{sh[63]}})
            return sh[63:0];
        else if (sh[159])
            return {1'b1, 63'b0};
        else
            return {1'b0, {63{1'b1}}};
    endfunction

    // Apply an accepted load to the predictor and queue any entries it causes.
    task automatic predict_load(input load_t ld);
        entry_t e;
        if (ld.row != 2'd3)
            proj_store[ld.camera * 12 + ld.row * 4 + ld.col] = ld.value;
        if (ld.last)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    e.r   = i[1:0];
                    e.c   = j[1:0];
                    e.v   = fund_entry(i, j);
                    e.eom = (i == 2 && j == 2);
                    entry_queue = {entry_queue, e};
                end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Driver: presents queued loads, idling at the current rate.
    always @(posedge clk or negedge rst_n)
    begin
        load_t nxt;
        bit    taken;
        bit    drive;
        if (!rst_n)
        begin
            start  <= 1'b0;
            camera <= 1'b0;
            row    <= '0;
            col    <= '0;
            value  <= '0;
            last   <= 1'b0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                predict_load(load_queue.pop_front());
                loads_taken++;
            end
            if (start && !taken)
                drive = 1'b1;
            else
                drive = (load_queue.size() > 0) && ($urandom_range(99) >= idle_pct);
            if (drive)
            begin
                nxt = load_queue[0];
                camera <= nxt.camera;
                row    <= nxt.row;
                col    <= nxt.col;
                value  <= nxt.value;
                last   <= nxt.last;
            end
            start <= drive;
        end
    end

    // Monitor: checks every emitted entry against the oldest prediction.
    always @(posedge clk)
    begin
        entry_t e;
        if (rst_n && result_valid)
        begin
            entries_seen++;
            if (entry_queue.size() == 0)
                report_mismatch("entry emitted with none predicted");
            else
            begin
                e = entry_queue.pop_front();
                if (out_row !== e.r || out_col !== e.c)
                    report_mismatch($sformatf("index (%0d,%0d) expected (%0d,%0d)",
                                              out_row, out_col, e.r, e.c));
                if (entry_value !== e.v)
                    report_mismatch($sformatf("entry (%0d,%0d) value %0d expected %0d",
                                              e.r, e.c, entry_value, e.v));
                if (end_of_matrix !== e.eom)
                    report_mismatch($sformatf("entry (%0d,%0d) end flag %b expected %b",
                                              e.r, e.c, end_of_matrix, e.eom));
            end
        end
    end

    // Watchdog on cycles with no transaction and no entry.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog expired with %0d loads and %0d entries pending",
                     load_queue.size(), entry_queue.size());
            $display("fundamental_from_projections_core regression: fail");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'($urandom);
            default: return $signed(32'($urandom_range(32'h1fffff))) - 32'sh100000;
        endcase
    endfunction

    function automatic load_t make_load(input int cam, input int r, input int c,
                                        input logic signed [31:0] v, input bit lst);
        load_t ld;
        ld.camera = cam[0];
        ld.row    = r[1:0];
        ld.col    = c[1:0];
        ld.value  = v;
        ld.last   = lst;
        return ld;
    endfunction

    // Stimulus and end of run.
    initial
    begin
        int  n;
        int  k;
        logic signed [31:0] v;
        rst_n = 1'b0;
        loads_taken = 0; entries_seen = 0; mismatches = 0;
        idle_pct = 26; quiet_cycles = 0; stim_done = 0;
        for (int a = 0; a < 24; a++)
            proj_store[a] = '0;

        // Directed: fill every element with extremes, zero, minus one, one-hot and scaled patterns.
        for (int a = 0; a < 24; a++)
        begin
            case (a % 6)
                0: v = 32'sh7fffffff;
                1: v = 32'sh80000000;
                2: v = 32'sh00000000;
                3: v = -32'sh1;
                4: v = 32'sh1 << (a % 31);
                default: v = 32'sh00001000 * (a - 10);
            endcase
            load_queue = {load_queue, make_load(a / 12, (a % 12) / 4, a % 4, v, 0)};
        end
        // Overflowing determinant, then a last on the unstored row index.
        load_queue = {load_queue, make_load(1, 2, 3, 32'sh55555555, 1)};
        load_queue = {load_queue, make_load(0, 3, 2, 32'shaaaaaaaa, 1)};

        // Random: rewrite sequences with random content, ending in a last.
        n = 0;
        while (n < NUM_RAND)
        begin
            k = $urandom_range(10, 2);
            for (int s = 0; s < k; s++)
            begin
                if ($urandom_range(9) == 0)
                    load_queue = {load_queue, make_load($urandom_range(1), 3,
                                  $urandom_range(3), 32'($urandom), 0)};
                else
                    load_queue = {load_queue, make_load($urandom_range(1),
                                  $urandom_range(2), $urandom_range(3), rand_value(), 0)};
                n++;
            end
            load_queue = {load_queue, make_load($urandom_range(1), $urandom_range(3),
                                                $urandom_range(3), rand_value(), 1)};
            n++;
        end
        n = load_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sender idle rate rises, then drops to zero as the run proceeds.
        wait (loads_taken >= n / 3);
        idle_pct = 74;
        wait (loads_taken >= 2 * n / 3);
        idle_pct = 0;
        wait (load_queue.size() == 0);
        wait (entry_queue.size() == 0);
        repeat (50) @(posedge clk);

        $display("Run covered %0d load transactions and %0d fundamental matrix entries.",
                 loads_taken, entries_seen);
        if (mismatches == 0)
            $display("fundamental_from_projections_core regression: pass");
        else
            $display("fundamental_from_projections_core regression: fail");
        $finish;
    end

endmodule
